// File: src/accel_sample_averager_macros.svh
`ifndef ACCEL_SAMPLE_AVERAGER_MACROS_SVH
`define ACCEL_SAMPLE_AVERAGER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/asa_pkg.sv
`default_nettype none

package asa_pkg;

  localparam int SUM_W                = 16;
  localparam int AXIS_W               = 10;
  localparam int OFF_W                = 12;
  localparam int BYTE_W               = 8;
  localparam int CFG_W                = 3;
  localparam int SHIFT_W              = $clog2(SUM_W);
  localparam int ONE_G_COUNTS         = 64;
  localparam int MAX_LOG2_SAMPLES_DEF = 6;

  // control shared by the three axis lanes
  typedef struct packed {
    logic               xfer;
    logic               clear;
    logic [SHIFT_W-1:0] shamt;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// File: src/asa_lane.sv
`default_nettype none

module asa_lane import asa_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lane_ctrl_t          ctrl,
  input  wire logic [BYTE_W-1:0]   low_byte,
  input  wire logic [BYTE_W-1:0]   high_byte,
  output logic      [SUM_W-1:0]    avg
);

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [AXIS_W-1:0] sample;
  logic [SUM_W-1:0]  sum_add;

  // only bits 1:0 of the high byte carry value bits
  assign sample  = {high_byte[1:0], low_byte};
  assign sum_add = sum_r + {{(SUM_W-AXIS_W){sample[AXIS_W-1]}}, sample};
  assign avg     = SUM_W'($signed(sum_add) >>> ctrl.shamt);

  always_comb begin
    sum_nxt = sum_r;
    if (ctrl.xfer) begin
      sum_nxt = ctrl.clear ? '0 : sum_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/accel_sample_averager.sv
`default_nettype none

// Three-axis sample averager. Each input transfer carries one sample as six raw
// register bytes; three axis lanes decode and accumulate them side by side, so a
// new sample is taken every cycle while the input is not stalled. After 2^log2_samples samples
// (clamped to MAX_LOG2_SAMPLES) the lane sums are shifted down to averages and,
// with the calibration offsets, loaded into the result register, which is
// visible the cycle after the block's last sample. The input stalls only while
// that register holds a result that the output side is stalling. Write
// log2_samples only while no block is in progress.

`include "accel_sample_averager_macros.svh"

module accel_sample_averager import asa_pkg::*; #(
  parameter int MAX_LOG2_SAMPLES = MAX_LOG2_SAMPLES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CFG_W-1:0]         cfg_wr_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [BYTE_W-1:0]        in_x_low_byte,
  input  wire logic [BYTE_W-1:0]        in_x_high_byte,
  input  wire logic [BYTE_W-1:0]        in_y_low_byte,
  input  wire logic [BYTE_W-1:0]        in_y_high_byte,
  input  wire logic [BYTE_W-1:0]        in_z_low_byte,
  input  wire logic [BYTE_W-1:0]        in_z_high_byte,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [AXIS_W-1:0]      out_avg_x,
  output logic signed [AXIS_W-1:0]      out_avg_y,
  output logic signed [AXIS_W-1:0]      out_avg_z,
  output logic signed [OFF_W-1:0]       out_cal_x,
  output logic signed [OFF_W-1:0]       out_cal_y,
  output logic signed [OFF_W-1:0]       out_cal_z
);

  localparam int CNT_W = MAX_LOG2_SAMPLES + 1;

  logic [CFG_W-1:0]   log2_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic [CNT_W-1:0]   cnt_add;
  logic [CNT_W-1:0]   block_len;
  logic [SHIFT_W-1:0] shamt;
  logic               in_xfer;
  logic               emit;
  lane_ctrl_t         lane_ctrl;

  logic [SUM_W-1:0]   avg_x;
  logic [SUM_W-1:0]   avg_y;
  logic [SUM_W-1:0]   avg_z;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [AXIS_W-1:0]  avg_x_r;
  logic [AXIS_W-1:0]  avg_y_r;
  logic [AXIS_W-1:0]  avg_z_r;
  logic [OFF_W-1:0]   off_x_r;
  logic [OFF_W-1:0]   off_y_r;
  logic [OFF_W-1:0]   off_z_r;
  logic [SUM_W-1:0]   off_x_full;
  logic [SUM_W-1:0]   off_y_full;
  logic [SUM_W-1:0]   off_z_full;

  assign shamt = (int'(log2_r) > MAX_LOG2_SAMPLES) ? SHIFT_W'(MAX_LOG2_SAMPLES)
                                                   : SHIFT_W'(log2_r);

  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;
  assign cnt_add   = cnt_r + CNT_W'(1);
  assign block_len = CNT_W'(1) << shamt;
  assign emit      = in_xfer & (cnt_add >= block_len);

  assign lane_ctrl.xfer  = in_xfer;
  assign lane_ctrl.clear = emit;
  assign lane_ctrl.shamt = shamt;

  asa_lane u_lane_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .low_byte  (in_x_low_byte),
    .high_byte (in_x_high_byte),
    .avg       (avg_x)
  );

  asa_lane u_lane_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .low_byte  (in_y_low_byte),
    .high_byte (in_y_high_byte),
    .avg       (avg_y)
  );

  asa_lane u_lane_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (lane_ctrl),
    .low_byte  (in_z_low_byte),
    .high_byte (in_z_high_byte),
    .avg       (avg_z)
  );

  // offsets are twice (bias minus average); z is biased by one g
  assign off_x_full = (SUM_W'(0) - avg_x) << 1;
  assign off_y_full = (SUM_W'(0) - avg_y) << 1;
  assign off_z_full = (SUM_W'(ONE_G_COUNTS) - avg_z) << 1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer) begin
      cnt_nxt = emit ? '0 : cnt_add;
    end
  end

  assign out_valid_nxt = emit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        log2_r <= cfg_wr_data;
      end
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      avg_x_r <= avg_x[AXIS_W-1:0];
      avg_y_r <= avg_y[AXIS_W-1:0];
      avg_z_r <= avg_z[AXIS_W-1:0];
      off_x_r <= off_x_full[OFF_W-1:0];
      off_y_r <= off_y_full[OFF_W-1:0];
      off_z_r <= off_z_full[OFF_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_avg_x = $signed(avg_x_r);
  assign out_avg_y = $signed(avg_y_r);
  assign out_avg_z = $signed(avg_z_r);
  assign out_cal_x = $signed(off_x_r);
  assign out_cal_y = $signed(off_y_r);
  assign out_cal_z = $signed(off_z_r);

  `ASA_ASSERT_NEXT(a_emit_clears_count, emit, cnt_r == '0, "count not cleared after result")
  `ASA_ASSERT_NOW(a_held_result_blocks_input, out_valid_r && out_stall, !in_xfer, "input taken over held result")
  `ASA_ASSERT_NEXT(a_single_sample_block, in_xfer && shamt == '0, out_valid_r, "no result for one-sample block")

endmodule

`default_nettype wire

// File: tb/sv/accel_sample_averager_test.sv
`default_nettype none

module accel_sample_averager_test;
  timeunit 1ns;
  timeprecision 1ps;

  import asa_pkg::*;

  localparam int MAX_LOG2   = MAX_LOG2_SAMPLES_DEF;
  localparam int LONG_HOLD  = 80;
  localparam int SETTLE     = 4;
  localparam int QUIET_MAX  = 1000;
  localparam int PHASE_ITEMS = 500;

  typedef struct packed {
    logic [BYTE_W-1:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
  } sample_t;

  typedef struct {
    logic signed [AXIS_W-1:0] avg_x, avg_y, avg_z;
    logic signed [OFF_W-1:0]  cal_x, cal_y, cal_z;
  } average_t;

  typedef enum int {MIX_RANDOM, MIX_EDGES, HOLD_MAX, HOLD_MIN} content_e;

  class average_scoreboard;
    bit [CFG_W-1:0]  log2_n;
    logic [SUM_W-1:0] sum_x, sum_y, sum_z;
    int unsigned     taken;
    average_t        expected_q[$];
    int              errors, samples, averages;

    function new();
      log2_n = '0;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      taken = 0;
      errors = 0;
      samples = 0;
      averages = 0;
    endfunction

    function void set_log2(bit [CFG_W-1:0] v);
      log2_n = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // sign-extended 10-bit count from the register byte pair
    function logic [SUM_W-1:0] axis_count(logic [BYTE_W-1:0] lo, logic [BYTE_W-1:0] hi);
      return {{(SUM_W-AXIS_W){hi[1]}}, hi[1:0], lo};
    endfunction

    function void note_sample(sample_t s);
      int unsigned n;
      logic signed [SUM_W-1:0] ax, ay, az, t;
      average_t r;
      n = (log2_n > MAX_LOG2) ? MAX_LOG2 : log2_n;
      sum_x += axis_count(s.x_lo, s.x_hi);
      sum_y += axis_count(s.y_lo, s.y_hi);
      sum_z += axis_count(s.z_lo, s.z_hi);
      taken++;
      samples++;
      // a counter already past 2^n still ends the block here
      if (taken < (1 << n)) return;
      ax = $signed(sum_x) >>> n;
      ay = $signed(sum_y) >>> n;
      az = $signed(sum_z) >>> n;
      r.avg_x = ax[AXIS_W-1:0];
      r.avg_y = ay[AXIS_W-1:0];
      r.avg_z = az[AXIS_W-1:0];
      t = (0 - ax) * 2;
      r.cal_x = t[OFF_W-1:0];
      t = (0 - ay) * 2;
      r.cal_y = t[OFF_W-1:0];
      t = (ONE_G_COUNTS - az) * 2;
      r.cal_z = t[OFF_W-1:0];
      expected_q.push_back(r);
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      taken = 0;
    endfunction

    function void compare(string field, logic signed [OFF_W-1:0] want,
                          logic signed [OFF_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_average(average_t got);
      average_t want;
      if (expected_q.size() == 0) begin
        $error("average transfer with nothing expected: avg_x=%0d avg_y=%0d avg_z=%0d",
               got.avg_x, got.avg_y, got.avg_z);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      averages++;
      compare("avg_x", want.avg_x, got.avg_x);
      compare("avg_y", want.avg_y, got.avg_y);
      compare("avg_z", want.avg_z, got.avg_z);
      compare("cal_x", want.cal_x, got.cal_x);
      compare("cal_y", want.cal_y, got.cal_y);
      compare("cal_z", want.cal_z, got.cal_z);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [BYTE_W-1:0] in_x_low_byte = '0, in_x_high_byte = '0;
  logic [BYTE_W-1:0] in_y_low_byte = '0, in_y_high_byte = '0;
  logic [BYTE_W-1:0] in_z_low_byte = '0, in_z_high_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AXIS_W-1:0] out_avg_x, out_avg_y, out_avg_z;
  logic signed [OFF_W-1:0]  out_cal_x, out_cal_y, out_cal_z;

  average_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int cfg_writes = 0;

  accel_sample_averager dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_low_byte (in_x_low_byte),
    .in_x_high_byte(in_x_high_byte),
    .in_y_low_byte (in_y_low_byte),
    .in_y_high_byte(in_y_high_byte),
    .in_z_low_byte (in_z_low_byte),
    .in_z_high_byte(in_z_high_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_avg_x     (out_avg_x),
    .out_avg_y     (out_avg_y),
    .out_avg_z     (out_avg_z),
    .out_cal_x     (out_cal_x),
    .out_cal_y     (out_cal_y),
    .out_cal_z     (out_cal_z)
  );

  always #10 clk = ~clk;

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    average_t got;
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_sample('{in_x_low_byte, in_x_high_byte, in_y_low_byte,
                         in_y_high_byte, in_z_low_byte, in_z_high_byte});
      if (out_valid && !out_stall) begin
        got.avg_x = out_avg_x;
        got.avg_y = out_avg_y;
        got.avg_z = out_avg_z;
        got.cal_x = out_cal_x;
        got.cal_y = out_cal_y;
        got.cal_z = out_cal_z;
        sb.check_average(got);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_MAX) begin
          $display("timeout: no transfer for %0d cycles", QUIET_MAX);
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic sample_t pack_counts(logic [AXIS_W-1:0] x, logic [AXIS_W-1:0] y,
                                          logic [AXIS_W-1:0] z, logic [5:0] fill);
    return '{x[7:0], {fill, x[9:8]}, y[7:0], {fill, y[9:8]}, z[7:0], {fill, z[9:8]}};
  endfunction

  function automatic logic [AXIS_W-1:0] axis_pick(content_e mode);
    logic [AXIS_W-1:0] corners[5] = '{10'h1FF, 10'h200, 10'h000, 10'h3FF, 10'h001};
    case (mode)
      HOLD_MAX:  return 10'h1FF;
      HOLD_MIN:  return 10'h200;
      MIX_EDGES: return corners[$urandom_range(4)];
      default:   return AXIS_W'($urandom_range(1023));
    endcase
  endfunction

  function automatic sample_t random_sample(content_e mode);
    sample_t s;
    s = pack_counts(axis_pick(mode), axis_pick(mode), axis_pick(mode), '0);
    // unused high-byte bits get random values on every axis
    s.x_hi[7:2] = 6'($urandom_range(63));
    s.y_hi[7:2] = 6'($urandom_range(63));
    s.z_hi[7:2] = 6'($urandom_range(63));
    return s;
  endfunction

  task automatic send_sample(sample_t s);
    // idle is chosen anew each clock, so the idle share of unstalled cycles is send_idle_pct
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_x_low_byte, in_x_high_byte, in_y_low_byte,
     in_y_high_byte, in_z_low_byte, in_z_high_byte} <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // sender stops until every expected average has been taken
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_log2(bit [CFG_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_log2(v);
    cfg_writes++;
  endtask

  // one average per sample while the receiver holds off, so the input backs up
  task automatic fill_and_hold();
    int keep_pct;
    keep_pct = send_idle_pct;
    write_log2(0);
    send_idle_pct = 0;
    hold_toggle <= ~hold_toggle;
    repeat (40) send_sample(random_sample(MIX_RANDOM));
    send_idle_pct = keep_pct;
    drain();
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    int items, n, count, r;
    content_e mode;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    fill_and_hold();
    items = 0;
    while (items < PHASE_ITEMS) begin
      n = $urandom_range(7);
      write_log2(CFG_W'(n));
      count = ((n >= 5) ? $urandom_range(1, 2) : $urandom_range(2, 8))
              << ((n > MAX_LOG2) ? MAX_LOG2 : n);
      // sometimes leave a partial block for the next setting to finish
      if ($urandom_range(3) == 0) count += $urandom_range(1, 3);
      r = $urandom_range(9);
      mode = (r == 0) ? HOLD_MAX : (r == 1) ? HOLD_MIN : (r < 4) ? MIX_EDGES : MIX_RANDOM;
      repeat (count) send_sample(random_sample(mode));
      items += count;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-sample averages across the full count range
    write_log2(0);
    send_sample(pack_counts(10'h000, 10'h000, 10'h000, 6'h00));
    send_sample(pack_counts(10'h3FF, 10'h3FF, 10'h3FF, 6'h3F));
    send_sample(pack_counts(10'h1FF, 10'h200, 10'h040, 6'h00));
    send_sample(pack_counts(10'h200, 10'h1FF, 10'h200, 6'h3F));
    send_sample(pack_counts(10'h0AA, 10'h155, 10'h03F, 6'h2A));
    send_sample(pack_counts(10'h001, 10'h2AA, 10'h041, 6'h15));

    // pair averages at both ends, then odd sums that round toward minus infinity
    write_log2(1);
    repeat (2) send_sample(pack_counts(10'h1FF, 10'h1FF, 10'h1FF, 6'h00));
    repeat (2) send_sample(pack_counts(10'h200, 10'h200, 10'h200, 6'h3F));
    send_sample(pack_counts(10'h001, 10'h3FF, 10'h3FD, 6'h00));
    send_sample(pack_counts(10'h000, 10'h000, 10'h000, 6'h00));

    // lower the setting mid-block: the count is already past the new size
    write_log2(6);
    repeat (3) send_sample(random_sample(MIX_EDGES));
    write_log2(1);
    send_sample(random_sample(MIX_EDGES));

    // out-of-range setting behaves as the largest one
    write_log2(7);
    repeat (64) send_sample(random_sample(HOLD_MIN));
    write_log2(7);
    repeat (64) send_sample(random_sample(MIX_EDGES));

    run_phase(33, 46);
    run_phase(46, 33);
    run_phase(0, 0);

    drain();
    $display("covered %0d samples, %0d averages checked, %0d log2_samples writes",
             sb.samples, sb.averages, cfg_writes);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
